[hdl/tfn_pkg.sv]
// Shared widths and types for the triangle face normal pipeline.
package tfn_pkg;

    localparam int COORD_BITS       = 32;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NUM_VERTS        = 9;
    localparam int OUT_W            = 16;

    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int HALF_W  = MAG_W / 2;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int QUOT_W  = NORMAL_FRAC_BITS + 1;
    localparam int DIV_W   = ROOT_W + 1;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
    } side_t;

endpackage

[hdl/triangle_face_normal_top.sv]
// Triangle face normal: edges, cross product, length, normalize to Q1.14.
// Pipeline from input transfer to output valid: 6 arithmetic stages,
// 67 square-root stages, 15 divider stages, 1 output register.
// Throughput: one triangle per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset (rst_n low, asynchronous) clears all valid bits; data is not reset.
module triangle_face_normal_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, 32 bits each
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // normal_x, normal_y, normal_z, 16 bits each
    output logic [47:0]  m_axis_tdata,
    // degenerate
    output logic         m_axis_tuser
);
    import tfn_pkg::*;

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [COORD_BITS-1:0] v [NUM_VERTS];
    always_comb
    begin
        for (int i = 0; i < NUM_VERTS; i++)
        begin
            v[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
        end
    end

    // stage 1: edges
    logic                     s1_vld_reg;
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    // stage 2: products
    logic                     s2_vld_reg;
    logic signed [PROD_W-1:0] p_reg [6];
    // stage 3: cross product magnitudes
    logic                     s3_vld_reg;
    side_t                    s3_side_reg;
    // stage 4: partial squares
    logic                     s4_vld_reg;
    side_t                    s4_side_reg;
    logic [MAG_W-1:0]         hh_reg [3];
    logic [MAG_W-1:0]         hl_reg [3];
    logic [MAG_W-1:0]         ll_reg [3];
    // stage 5: squares
    logic                     s5_vld_reg;
    side_t                    s5_side_reg;
    logic [SQ_W-1:0]          sq_reg [3];
    // stage 6: sum of squares
    logic                     s6_vld_reg;
    side_t                    s6_side_reg;
    logic [SUM_W-1:0]         sum_reg;

    logic signed [CROSS_W-1:0] c_next [3];
    side_t                     s3_side_next;
    logic [SUM_W-1:0]          sum_next;
    side_t                     s6_side_next;

    always_comb
    begin
        c_next[0] = p_reg[0] - p_reg[1];
        c_next[1] = p_reg[2] - p_reg[3];
        c_next[2] = p_reg[4] - p_reg[5];
        s3_side_next.degen = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            s3_side_next.neg[i] = c_next[i][CROSS_W-1];
            s3_side_next.mag[i] = MAG_W'(c_next[i][CROSS_W-1] ? -c_next[i] : c_next[i]);
        end
        sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        s6_side_next       = s5_side_reg;
        s6_side_next.degen = (sum_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= s_axis_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EDGE_W'(v[3+i]) - EDGE_W'(v[i]);
                e2_reg[i] <= EDGE_W'(v[6+i]) - EDGE_W'(v[i]);
            end
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
            s3_side_reg <= s3_side_next;
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= MAG_W'(s3_side_reg.mag[i][MAG_W-1 -: HALF_W])
                           * MAG_W'(s3_side_reg.mag[i][MAG_W-1 -: HALF_W]);
                hl_reg[i] <= MAG_W'(s3_side_reg.mag[i][MAG_W-1 -: HALF_W])
                           * MAG_W'(s3_side_reg.mag[i][HALF_W-1:0]);
                ll_reg[i] <= MAG_W'(s3_side_reg.mag[i][HALF_W-1:0])
                           * MAG_W'(s3_side_reg.mag[i][HALF_W-1:0]);
            end
            s4_side_reg <= s3_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= (SQ_W'(hh_reg[i]) << (2 * HALF_W))
                           + (SQ_W'(hl_reg[i]) << (HALF_W + 1))
                           + SQ_W'(ll_reg[i]);
            end
            s5_side_reg <= s4_side_reg;
            sum_reg     <= sum_next;
            s6_side_reg <= s6_side_next;
        end
    end

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    tfn_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_vld_reg),
        .in_sum    (sum_reg),
        .in_side   (s6_side_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    logic                   dv_vld;
    logic [2:0][QUOT_W-1:0] dv_quot;
    logic [2:0]             dv_neg;
    logic                   dv_degen;

    tfn_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_vld),
        .in_len    (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_vld),
        .out_quot  (dv_quot),
        .out_neg   (dv_neg),
        .out_degen (dv_degen)
    );

    logic              out_vld_reg;
    logic [47:0]       out_data_reg;
    logic              out_degen_reg;
    logic [47:0]       out_data_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_degen)
            begin
                out_data_next[i*OUT_W +: OUT_W] = '0;
            end
            else if (dv_neg[i])
            begin
                out_data_next[i*OUT_W +: OUT_W] = OUT_W'(0) - OUT_W'(dv_quot[i]);
            end
            else
            begin
                out_data_next[i*OUT_W +: OUT_W] = OUT_W'(dv_quot[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg  <= out_data_next;
            out_degen_reg <= dv_degen;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_degen_reg;

endmodule

[hdl/tfn_sqrt.sv]
// Pipelined digit-by-digit integer square root, one root bit per stage.
module tfn_sqrt
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [tfn_pkg::SUM_W-1:0] in_sum,
    input  tfn_pkg::side_t            in_side,
    output logic                      out_valid,
    output logic [tfn_pkg::ROOT_W-1:0] out_root,
    output tfn_pkg::side_t            out_side
);
    import tfn_pkg::*;

    logic              vld_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SUM_W-1:0]  sum_reg  [ROOT_W];
    side_t             side_reg [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic              vld_prev;
            logic [REM_W-1:0]  rem_prev;
            logic [ROOT_W-1:0] root_prev;
            logic [SUM_W-1:0]  sum_prev;
            side_t             side_prev;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              take;

            if (k == 0)
            begin : g_first
                assign vld_prev  = in_valid;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign sum_prev  = in_sum;
                assign side_prev = in_side;
            end
            else
            begin : g_next
                assign vld_prev  = vld_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign sum_prev  = sum_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            assign rem_sh = {rem_prev[REM_W-3:0], sum_prev[SUM_W-1 -: 2]};
            assign trial  = {1'b0, root_prev, 2'b01};
            assign take   = (rem_sh >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                    root_reg[k] <= {root_prev[ROOT_W-2:0], take};
                    sum_reg[k]  <= {sum_prev[SUM_W-3:0], 2'b00};
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

[hdl/tfn_div.sv]
// Pipelined restoring divider: three lanes of |c| * 2^frac / length.
module tfn_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [tfn_pkg::ROOT_W-1:0] in_len,
    input  tfn_pkg::side_t             in_side,
    output logic                       out_valid,
    output logic [2:0][tfn_pkg::QUOT_W-1:0] out_quot,
    output logic [2:0]                 out_neg,
    output logic                       out_degen
);
    import tfn_pkg::*;

    logic                   vld_reg  [QUOT_W];
    logic [2:0][DIV_W-1:0]  rem_reg  [QUOT_W];
    logic [2:0][QUOT_W-1:0] quot_reg [QUOT_W];
    logic [ROOT_W-1:0]      len_reg  [QUOT_W];
    logic [2:0]             neg_reg  [QUOT_W];
    logic                   degen_reg[QUOT_W];

    genvar k, l;
    generate
        for (k = 0; k < QUOT_W; k++)
        begin : g_stage
            logic                   vld_prev;
            logic [2:0][DIV_W-1:0]  rem_prev;
            logic [2:0][QUOT_W-1:0] quot_prev;
            logic [ROOT_W-1:0]      len_prev;
            logic [2:0]             neg_prev;
            logic                   degen_prev;
            logic [2:0][DIV_W-1:0]  rem_new;
            logic [2:0][QUOT_W-1:0] quot_new;

            if (k == 0)
            begin : g_first
                assign vld_prev   = in_valid;
                assign quot_prev  = '0;
                assign len_prev   = in_len;
                assign neg_prev   = in_side.neg;
                assign degen_prev = in_side.degen;
                for (l = 0; l < 3; l++)
                begin : g_m
                    assign rem_prev[l] = DIV_W'(in_side.mag[l]);
                end
            end
            else
            begin : g_next
                assign vld_prev   = vld_reg[k-1];
                assign rem_prev   = rem_reg[k-1];
                assign quot_prev  = quot_reg[k-1];
                assign len_prev   = len_reg[k-1];
                assign neg_prev   = neg_reg[k-1];
                assign degen_prev = degen_reg[k-1];
            end

            for (l = 0; l < 3; l++)
            begin : g_lane
                logic [DIV_W-1:0] r_sh;
                logic             take;
                if (k == 0)
                begin : g_ns
                    assign r_sh = rem_prev[l];
                end
                else
                begin : g_sh
                    assign r_sh = {rem_prev[l][DIV_W-2:0], 1'b0};
                end
                assign take        = (r_sh >= DIV_W'(len_prev));
                assign rem_new[l]  = take ? (r_sh - DIV_W'(len_prev)) : r_sh;
                assign quot_new[l] = {quot_prev[l][QUOT_W-2:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]   <= rem_new;
                    quot_reg[k]  <= quot_new;
                    len_reg[k]   <= len_prev;
                    neg_reg[k]   <= neg_prev;
                    degen_reg[k] <= degen_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QUOT_W-1];
    assign out_quot  = quot_reg[QUOT_W-1];
    assign out_neg   = neg_reg[QUOT_W-1];
    assign out_degen = degen_reg[QUOT_W-1];

endmodule

[sim/triangle_face_normal_top_tb.sv]
// Testbench for triangle_face_normal_top: predicts each unit normal and checks the stream.
`timescale 1ns / 1ps

module triangle_face_normal_top_tb;
    import tfn_pkg::*;

    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } normal_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tuser;

    normal_t expected_normals[$];
    int          mismatches;
    int          unexpected;
    bit          idle_enable;
    int          hold_cycles;

    triangle_face_normal_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [80:0] isqrt_floor(logic [135:0] s);
        logic [80:0]  root;
        logic [80:0]  cand;
        logic [161:0] sq;
        root = '0;
        for (int b = 67; b >= 0; b--)
        begin
            cand = root | (81'(1) << b);
            sq = 162'(cand) * 162'(cand);
            if (sq <= 162'(s))
                root = cand;
        end
        return root;
    endfunction

    function automatic normal_t face_normal(logic [287:0] tri_data);
        logic signed [31:0]  v[9];
        logic signed [66:0]  e1[3];
        logic signed [66:0]  e2[3];
        logic signed [135:0] c[3];
        logic [135:0]        mag[3];
        logic [135:0]        sum;
        logic [80:0]         len;
        logic [135:0]        q;
        logic [15:0]         comp[3];
        normal_t             r;
        for (int i = 0; i < 9; i++)
            v[i] = tri_data[32*i +: 32];
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = 67'(v[3+i]) - 67'(v[i]);
            e2[i] = 67'(v[6+i]) - 67'(v[i]);
        end
        c[0] = 136'(e1[1]) * 136'(e2[2]) - 136'(e1[2]) * 136'(e2[1]);
        c[1] = 136'(e1[2]) * 136'(e2[0]) - 136'(e1[0]) * 136'(e2[2]);
        c[2] = 136'(e1[0]) * 136'(e2[1]) - 136'(e1[1]) * 136'(e2[0]);
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = c[i] < 0 ? 136'(-c[i]) : 136'(c[i]);
            sum += mag[i] * mag[i];
        end
        if (sum == 0)
        begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
            return r;
        end
        len = isqrt_floor(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] << NORMAL_FRAC_BITS) / 136'(len);
            comp[i] = c[i] < 0 ? 16'(-q) : 16'(q);
        end
        r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.degen = 1'b0;
        return r;
    endfunction

    task automatic send_triangle(logic [287:0] tri_data);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tri_data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_normals.push_back(face_normal(tri_data));
    endtask

    task automatic go_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        go_quiet();
        while (expected_normals.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [287:0] make_triangle(logic [31:0] p[9]);
        logic [287:0] d;
        for (int i = 0; i < 9; i++)
            d[32*i +: 32] = p[i];
        return d;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1024)) - 512) << 16;
            2: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                          : 32'h80000000 + $urandom_range(0, 3);
            3: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) << 8;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] p[9];
        p = '{default: 32'h0};
        send_triangle(make_triangle(p));
        p = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};
        send_triangle(make_triangle(p));
        p = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0};
        send_triangle(make_triangle(p));
        p = '{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0};
        send_triangle(make_triangle(p));
        p = '{0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        send_triangle(make_triangle(p));
        p = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h20000};
        send_triangle(make_triangle(p));
        p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
        send_triangle(make_triangle(p));
        p = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        send_triangle(make_triangle(p));
        p = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF};
        send_triangle(make_triangle(p));
        p = '{default: 32'hFFFFFFFF};
        send_triangle(make_triangle(p));
        p = '{default: 32'h7FFFFFFF};
        send_triangle(make_triangle(p));
        p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_triangle(make_triangle(p));
        p = '{5, 5, 5, 6, 5, 5, 5, 5, 4};
        send_triangle(make_triangle(p));
        p = '{0, 0, 0, 3, 4, 0, 32'hFFFFFFFD, 32'hFFFFFFFC, 0};
        send_triangle(make_triangle(p));
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [31:0] p[9];
        for (int n = 0; n < count; n++)
        begin
            foreach (p[i])
                p[i] = rand_coord();
            // collinear or repeated vertices
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
                1: for (int i = 0; i < 3; i++) p[3+i] = p[i];
                2: for (int i = 0; i < 3; i++) p[6+i] = 2*p[3+i] - p[i];
                default: ;
            endcase
            send_triangle(make_triangle(p));
        end
    endtask

    task automatic test_backpressure();
        logic [31:0] p[9];
        hold_cycles = 300;
        for (int n = 0; n < 150; n++)
        begin
            foreach (p[i])
                p[i] = rand_coord();
            send_triangle(make_triangle(p));
        end
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        idle_enable   = 1'b1;
        hold_cycles   = 0;
        mismatches    = 0;
        unexpected    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        drain_results();
        test_backpressure();
        idle_enable = 1'b0;
        test_random(700);
        drain_results();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && unexpected == 0 && expected_normals.size() == 0)
            $display("triangle_face_normal_top verification clean");
        else
            $display("triangle_face_normal_top verification failed");
        $finish;
    end

    // receiver: random stalls while idle_enable is set, plus one long hold-off when requested
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles   <= hold_cycles - 1;
            end
            else if (idle_enable)
                m_axis_tready <= $urandom_range(0, 3) != 0;
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        normal_t got;
        normal_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.nx    = m_axis_tdata[15:0];
            got.ny    = m_axis_tdata[31:16];
            got.nz    = m_axis_tdata[47:32];
            got.degen = m_axis_tuser;
            if (expected_normals.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected transfer: %h deg=%b", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = expected_normals.pop_front();
                if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz
                    || got.degen !== want.degen)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: exp %h %h %h deg=%b got %h %h %h deg=%b",
                                 want.nx, want.ny, want.nz, want.degen,
                                 got.nx, got.ny, got.nz, got.degen);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("triangle_face_normal_top verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/tfn_pkg.sv
hdl/tfn_sqrt.sv
hdl/tfn_div.sv
hdl/triangle_face_normal_top.sv
sim/triangle_face_normal_top_tb.sv
